FILE: hw/rtl/led_palette_fade_lamp_controller_defines.svh
// ---------------------------------------------------------------------------
// Lamp controller assertion macros
// Shared helpers for concurrent checks on the lamp controller ports.
// ---------------------------------------------------------------------------
`ifndef LED_PALETTE_FADE_LAMP_CONTROLLER_DEFINES_SVH
`define LED_PALETTE_FADE_LAMP_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPFLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPFLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lpflc_pkg.sv
// ---------------------------------------------------------------------------
// Lamp controller package
// Widths, register indexes, reset values and the sequencer state type.
// ---------------------------------------------------------------------------
package lpflc_pkg;

  localparam int PALETTE_DEPTH_DEF = 8;
  localparam int CH_W      = 8;
  localparam int COLOR_W   = 3 * CH_W;
  localparam int MUL_W     = CH_W + 1;
  localparam int PROD_W    = CH_W + MUL_W;
  localparam int TIME_W    = 32;
  localparam int DEB_W     = 16;
  localparam int PCOUNT_W  = 4;
  localparam int ENTRY_W   = 3;
  localparam int CFG_IDX_W = 3;
  localparam int BLEND_STEPS = 255;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [COLOR_W-1:0]   color_t;
  typedef logic [CH_W-1:0]      chan_t;

  // Register indexes on the configuration port.
  localparam cfg_idx_t REG_IR_MODE      = 3'd0;
  localparam cfg_idx_t REG_IR_TRIGGER   = 3'd1;
  localparam cfg_idx_t REG_MULTI_MODE   = 3'd2;
  localparam cfg_idx_t REG_SINGLE_COLOR = 3'd3;
  localparam cfg_idx_t REG_PAL_COUNT    = 3'd4;
  localparam cfg_idx_t REG_BRIGHTNESS   = 3'd5;
  localparam cfg_idx_t REG_DEBOUNCE     = 3'd6;

  // Register reset values.
  localparam color_t           SINGLE_COLOR_RST = 24'hFFE7BA;
  localparam chan_t            BRIGHTNESS_RST   = 8'd255;
  localparam logic [DEB_W-1:0] DEBOUNCE_RST     = 16'd100;

  // Last blend step before the fade moves on to the next colour pair.
  localparam chan_t BLEND_LAST = CH_W'(BLEND_STEPS - 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD,
    ST_ADDR_A,
    ST_ADDR_B,
    ST_FETCH_B,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_D,
    ST_OUT
  } state_t;

endpackage

FILE: hw/rtl/lpflc_ram.sv
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lpflc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Storage and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/led_palette_fade_lamp_controller.sv
// ---------------------------------------------------------------------------
// Palette fade lamp controller
// Button and motion sensor lamp control with solid colour or palette fade.
// ---------------------------------------------------------------------------
// Usage:
// The input channel carries one request per item. With in_op low it is a
// frame tick with button level, sensor level and timestamp, and it always
// yields one result. With in_op high it writes one palette entry and yields
// no result. Registers are written over the cfg_ port, which is always ready.
// Work per frame: a frame that pushes nothing goes straight to the output
// stage, a solid-colour push runs one brightness product per channel on
// the shared bit-serial multiplier, and a fade frame runs the serial modulo
// of the palette index, two reads of the palette RAM and three products per
// channel. The next request is taken once the controller is back in idle
// after the result is written.
// in_stall is high while a frame is being worked on. A finished result sits
// in the output register while the receiver stalls, and the next request can
// be taken meanwhile; it then waits before its own result is written.
// Synchronous reset returns registers and lamp state to their defaults; the
// palette contents are undefined until written.
// ---------------------------------------------------------------------------
module led_palette_fade_lamp_controller #(
  parameter int PALETTE_DEPTH = lpflc_pkg::PALETTE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  lpflc_pkg::cfg_idx_t                   cfg_index,
  input  lpflc_pkg::color_t                     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_op,
  input  logic                                  in_button_level,
  input  logic                                  in_sensor_level,
  input  logic [lpflc_pkg::TIME_W-1:0]          in_now_ms,
  input  logic [lpflc_pkg::ENTRY_W-1:0]         in_entry_index,
  input  lpflc_pkg::color_t                     in_entry_color,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output lpflc_pkg::chan_t                      out_red,
  output lpflc_pkg::chan_t                      out_green,
  output lpflc_pkg::chan_t                      out_blue,
  output logic                                  out_lamp_is_on,
  output logic                                  out_refresh
);

  import lpflc_pkg::*;

  localparam int TI_W    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(PALETTE_DEPTH + 1);
  localparam int PCW     = (CNT_W > PCOUNT_W) ? CNT_W : PCOUNT_W;
  localparam int IW      = (TI_W > ENTRY_W) ? TI_W : ENTRY_W;
  localparam int SEQ_MAX = (TI_W > MUL_W) ? TI_W : MUL_W;
  localparam int SEQ_W   = $clog2(SEQ_MAX);

  // Configuration registers.
  logic                ir_mode_r, ir_mode_nxt;
  logic                ir_trig_r, ir_trig_nxt;
  logic                multi_r, multi_nxt;
  color_t              single_r, single_nxt;
  logic [PCOUNT_W-1:0] pcount_r, pcount_nxt;
  chan_t               bright_r, bright_nxt;
  logic [DEB_W-1:0]    debounce_r, debounce_nxt;

  // Lamp and fade state.
  logic              prior_btn_r, prior_btn_nxt;
  logic [TIME_W-1:0] last_press_r, last_press_nxt;
  logic              lamp_on_r, lamp_on_nxt;
  logic              prior_lamp_r, prior_lamp_nxt;
  chan_t             step_r, step_nxt;
  logic [TI_W-1:0]   target_r, target_nxt;

  // Sequencer and datapath.
  state_t            state_r, state_nxt;
  logic [SEQ_W-1:0]  cnt_r, cnt_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic              fade_r, fade_nxt;
  logic              wrap_r, wrap_nxt;
  logic              push_r, push_nxt;
  chan_t             t_r, t_nxt;
  logic [TI_W-1:0]   div_r, div_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  color_t            ca_r, ca_nxt;
  color_t            cb_r, cb_nxt;
  logic [PROD_W-1:0] acc_r, acc_nxt;
  logic [PROD_W-1:0] mc_r, mc_nxt;
  logic [MUL_W-1:0]  mr_r, mr_nxt;
  logic [MUL_W-1:0]  sum_r, sum_nxt;
  color_t            res_r, res_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  color_t            out_col_r, out_col_nxt;
  logic              out_lamp_r, out_lamp_nxt;
  logic              out_refresh_r, out_refresh_nxt;

  // Combinational helpers.
  logic [PCW-1:0]    count_wide;
  logic [CNT_W-1:0]  count_eff;
  logic              fade_now;
  logic [TIME_W-1:0] elapsed;
  logic              press_ok;
  logic              lamp_new;
  logic              push_new;
  logic [CNT_W:0]    mod_sh;
  logic [CNT_W:0]    mod_sub;
  logic [CNT_W-1:0]  a_plus;
  logic [CNT_W-1:0]  b_wide;
  logic [TI_W-1:0]   a_idx;
  logic [TI_W-1:0]   b_idx;
  logic [PROD_W-1:0] acc_step;
  logic [MUL_W-1:0]  mix_sum;
  logic              mul_last;
  logic              mod_last;
  logic              frame_acc;
  logic [IW-1:0]     entry_ext;
  logic              ram_we;
  logic              ram_re;
  logic [TI_W-1:0]   ram_raddr;
  color_t            ram_rdata;

  // Palette store.
  lpflc_ram #(
    .WIDTH(COLOR_W),
    .DEPTH(PALETTE_DEPTH)
  ) u_palette (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(entry_ext[TI_W-1:0]),
    .wr_data(in_entry_color),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rdata)
  );

  // Frame decision logic for the request at the input.
  always_comb begin
    count_wide = (PCW'(pcount_r) > PCW'(PALETTE_DEPTH)) ? PCW'(PALETTE_DEPTH)
                                                        : PCW'(pcount_r);
    count_eff  = count_wide[CNT_W-1:0];
    fade_now   = multi_r && (count_eff != '0);
    elapsed    = in_now_ms - last_press_r;
    press_ok   = !in_button_level && prior_btn_r && (elapsed > TIME_W'(debounce_r));
    lamp_new   = ir_mode_r ? (in_sensor_level == ir_trig_r) : (lamp_on_r ^ press_ok);
    push_new   = lamp_new ? (!prior_lamp_r || fade_now) : prior_lamp_r;
  end

  // Serial modulo step, neighbour index and multiplier step.
  always_comb begin
    mod_sh   = {rem_r, div_r[TI_W-1]};
    mod_sub  = mod_sh - {1'b0, count_eff};
    a_plus   = rem_r + CNT_W'(1);
    b_wide   = (a_plus == count_eff) ? '0 : a_plus;
    a_idx    = rem_r[TI_W-1:0];
    b_idx    = b_wide[TI_W-1:0];
    acc_step = acc_r + (mr_r[0] ? mc_r : '0);
    mix_sum  = sum_r + acc_step[PROD_W-1:CH_W];
    mul_last = (cnt_r == SEQ_W'(MUL_W - 1));
    mod_last = (cnt_r == SEQ_W'(TI_W - 1));
  end

  // Palette port control.
  assign frame_acc = in_valid && !in_stall && !in_op;
  assign entry_ext = IW'(in_entry_index);
  assign ram_we    = in_valid && !in_stall && in_op &&
                     (int'(in_entry_index) < PALETTE_DEPTH);
  assign ram_re    = (state_r == ST_ADDR_A) || (state_r == ST_ADDR_B);
  assign ram_raddr = (state_r == ST_ADDR_A) ? a_idx : b_idx;

  // Next state and datapath control.
  always_comb begin
    ir_mode_nxt     = ir_mode_r;
    ir_trig_nxt     = ir_trig_r;
    multi_nxt       = multi_r;
    single_nxt      = single_r;
    pcount_nxt      = pcount_r;
    bright_nxt      = bright_r;
    debounce_nxt    = debounce_r;
    prior_btn_nxt   = prior_btn_r;
    last_press_nxt  = last_press_r;
    lamp_on_nxt     = lamp_on_r;
    prior_lamp_nxt  = prior_lamp_r;
    step_nxt        = step_r;
    target_nxt      = target_r;
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    ch_nxt          = ch_r;
    fade_nxt        = fade_r;
    wrap_nxt        = wrap_r;
    push_nxt        = push_r;
    t_nxt           = t_r;
    div_nxt         = div_r;
    rem_nxt         = rem_r;
    ca_nxt          = ca_r;
    cb_nxt          = cb_r;
    acc_nxt         = acc_r;
    mc_nxt          = mc_r;
    mr_nxt          = mr_r;
    sum_nxt         = sum_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_col_nxt     = out_col_r;
    out_lamp_nxt    = out_lamp_r;
    out_refresh_nxt = out_refresh_r;

    // Register writes.
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IR_MODE:      ir_mode_nxt  = cfg_data[0];
        REG_IR_TRIGGER:   ir_trig_nxt  = cfg_data[0];
        REG_MULTI_MODE:   multi_nxt    = cfg_data[0];
        REG_SINGLE_COLOR: single_nxt   = cfg_data;
        REG_PAL_COUNT:    pcount_nxt   = cfg_data[PCOUNT_W-1:0];
        REG_BRIGHTNESS:   bright_nxt   = cfg_data[CH_W-1:0];
        REG_DEBOUNCE:     debounce_nxt = cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end

    // The receiver takes the waiting result.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (frame_acc) begin
          prior_btn_nxt  = in_button_level;
          if (press_ok) begin
            last_press_nxt = in_now_ms;
          end
          lamp_on_nxt    = lamp_new;
          prior_lamp_nxt = lamp_new;
          push_nxt       = push_new;
          fade_nxt       = lamp_new && fade_now;
          t_nxt          = step_r;
          wrap_nxt       = (step_r == BLEND_LAST);
          ch_nxt         = '0;
          cnt_nxt        = '0;
          res_nxt        = '0;
          if (lamp_new && fade_now) begin
            step_nxt  = (step_r == BLEND_LAST) ? '0 : step_r + 1'b1;
            div_nxt   = target_r;
            rem_nxt   = '0;
            state_nxt = ST_MOD;
          end else if (push_new) begin
            // Solid colour on turn-on, black on turn-off.
            ca_nxt    = lamp_new ? single_r : '0;
            acc_nxt   = '0;
            mc_nxt    = PROD_W'(lamp_new ? single_r[COLOR_W-1 -: CH_W] : '0);
            mr_nxt    = MUL_W'(bright_r) + MUL_W'(1);
            state_nxt = ST_MUL_D;
          end else begin
            state_nxt = ST_OUT;
          end
        end
      end

      // Restoring remainder of the palette index, one bit per cycle.
      ST_MOD: begin
        rem_nxt = mod_sub[CNT_W] ? mod_sh[CNT_W-1:0] : mod_sub[CNT_W-1:0];
        div_nxt = div_r << 1;
        cnt_nxt = cnt_r + 1'b1;
        if (mod_last) begin
          state_nxt = ST_ADDR_A;
        end
      end

      ST_ADDR_A: begin
        if (wrap_r) begin
          target_nxt = b_idx;
        end
        state_nxt = ST_ADDR_B;
      end

      ST_ADDR_B: begin
        ca_nxt    = ram_rdata;
        state_nxt = ST_FETCH_B;
      end

      ST_FETCH_B: begin
        cb_nxt    = ram_rdata;
        acc_nxt   = '0;
        cnt_nxt   = '0;
        mc_nxt    = PROD_W'(ca_r[COLOR_W-1 -: CH_W]);
        mr_nxt    = MUL_W'(1 << CH_W) - MUL_W'(t_r);
        state_nxt = ST_MUL_A;
      end

      // Shift-add multiply, shared by blend and brightness products.
      ST_MUL_A, ST_MUL_B, ST_MUL_D: begin
        acc_nxt = acc_step;
        mc_nxt  = mc_r << 1;
        mr_nxt  = mr_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (mul_last) begin
          acc_nxt = '0;
          cnt_nxt = '0;
          if (state_r == ST_MUL_A) begin
            sum_nxt   = acc_step[PROD_W-1:CH_W];
            mc_nxt    = PROD_W'(cb_r[COLOR_W-1 -: CH_W]);
            mr_nxt    = MUL_W'(t_r) + MUL_W'(1);
            state_nxt = ST_MUL_B;
          end else if (state_r == ST_MUL_B) begin
            mc_nxt    = PROD_W'(mix_sum[CH_W-1:0]);
            mr_nxt    = MUL_W'(bright_r) + MUL_W'(1);
            state_nxt = ST_MUL_D;
          end else begin
            res_nxt = {res_r[COLOR_W-CH_W-1:0], acc_step[2*CH_W-1:CH_W]};
            ca_nxt  = {ca_r[COLOR_W-CH_W-1:0], {CH_W{1'b0}}};
            cb_nxt  = {cb_r[COLOR_W-CH_W-1:0], {CH_W{1'b0}}};
            ch_nxt  = ch_r + 1'b1;
            if (ch_r == 2'd2) begin
              state_nxt = ST_OUT;
            end else if (fade_r) begin
              mc_nxt    = PROD_W'(ca_r[COLOR_W-CH_W-1 -: CH_W]);
              mr_nxt    = MUL_W'(1 << CH_W) - MUL_W'(t_r);
              state_nxt = ST_MUL_A;
            end else begin
              mc_nxt    = PROD_W'(ca_r[COLOR_W-CH_W-1 -: CH_W]);
              mr_nxt    = MUL_W'(bright_r) + MUL_W'(1);
              state_nxt = ST_MUL_D;
            end
          end
        end
      end

      // Hand the result over once the output register is free.
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt   = 1'b1;
          out_col_nxt     = res_r;
          out_lamp_nxt    = lamp_on_r;
          out_refresh_nxt = push_r;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Register update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ir_mode_r    <= 1'b0;
      ir_trig_r    <= 1'b0;
      multi_r      <= 1'b0;
      single_r     <= SINGLE_COLOR_RST;
      pcount_r     <= '0;
      bright_r     <= BRIGHTNESS_RST;
      debounce_r   <= DEBOUNCE_RST;
      prior_btn_r  <= 1'b1;
      last_press_r <= '0;
      lamp_on_r    <= 1'b1;
      prior_lamp_r <= 1'b1;
      step_r       <= '0;
      target_r     <= '0;
      state_r      <= ST_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      ir_mode_r     <= ir_mode_nxt;
      ir_trig_r     <= ir_trig_nxt;
      multi_r       <= multi_nxt;
      single_r      <= single_nxt;
      pcount_r      <= pcount_nxt;
      bright_r      <= bright_nxt;
      debounce_r    <= debounce_nxt;
      prior_btn_r   <= prior_btn_nxt;
      last_press_r  <= last_press_nxt;
      lamp_on_r     <= lamp_on_nxt;
      prior_lamp_r  <= prior_lamp_nxt;
      step_r        <= step_nxt;
      target_r      <= target_nxt;
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      cnt_r         <= cnt_nxt;
      ch_r          <= ch_nxt;
      fade_r        <= fade_nxt;
      wrap_r        <= wrap_nxt;
      push_r        <= push_nxt;
      t_r           <= t_nxt;
      div_r         <= div_nxt;
      rem_r         <= rem_nxt;
      ca_r          <= ca_nxt;
      cb_r          <= cb_nxt;
      acc_r         <= acc_nxt;
      mc_r          <= mc_nxt;
      mr_r          <= mr_nxt;
      sum_r         <= sum_nxt;
      res_r         <= res_nxt;
      out_col_r     <= out_col_nxt;
      out_lamp_r    <= out_lamp_nxt;
      out_refresh_r <= out_refresh_nxt;
    end
  end

  // Port drive.
  assign cfg_ready      = 1'b1;
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_red        = out_col_r[COLOR_W-1 -: CH_W];
  assign out_green      = out_col_r[COLOR_W-CH_W-1 -: CH_W];
  assign out_blue       = out_col_r[CH_W-1:0];
  assign out_lamp_is_on = out_lamp_r;
  assign out_refresh    = out_refresh_r;

endmodule

FILE: hw/rtl/lpflc_checker.sv
// ---------------------------------------------------------------------------
// Lamp controller port checker
// Concurrent checks on the top-level ports, bound to the controller.
// ---------------------------------------------------------------------------
`include "led_palette_fade_lamp_controller_defines.svh"

module lpflc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          in_op,
  input logic                          out_valid,
  input logic                          out_stall,
  input lpflc_pkg::chan_t              out_red,
  input lpflc_pkg::chan_t              out_green,
  input lpflc_pkg::chan_t              out_blue,
  input logic                          out_lamp_is_on,
  input logic                          out_refresh
);

  // A stalled result stays put.
  `LPFLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
    out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) &&
    $stable(out_lamp_is_on) && $stable(out_refresh), "stalled result changed")

  // A frame request keeps the input busy for at least the next cycle.
  `LPFLC_ASSERT_NEXT(a_frame_busy, clk, rst_n, in_valid && !in_stall && !in_op,
    in_stall, "input ready straight after a frame request")

  // A frame that pushes nothing reports a black colour.
  `LPFLC_ASSERT_NOW(a_no_push_black, clk, rst_n, out_valid && !out_refresh,
    out_red == '0 && out_green == '0 && out_blue == '0, "colour without refresh")

  // A lamp that is off never shows light.
  `LPFLC_ASSERT_NOW(a_off_black, clk, rst_n, out_valid && !out_lamp_is_on,
    out_red == '0 && out_green == '0 && out_blue == '0, "colour with lamp off")

endmodule

bind led_palette_fade_lamp_controller lpflc_checker u_lpflc_checker (.*);
